@@ sv/acr_pkg.sv @@
`default_nettype none
package acr_pkg;

  localparam int W        = 21;
  localparam int VEC_W    = 3 * W;
  localparam int PROPS_W  = 50;
  localparam int PUSH_W   = W + 2;
  localparam int D_W      = W + 4;
  localparam int PROD_W   = 38;
  localparam int NUM_W    = 40;
  localparam int MASS_W   = 16;
  localparam int DEN_W    = MASS_W + 1;
  localparam int REM_W    = DEN_W;
  localparam int Q_W      = W;
  localparam int RPROD_W  = W + DEN_W + 1;
  localparam int DIV_STEPS = Q_W;
  localparam int LANES    = 6;
  localparam int REFL_SHIFT = 13;

  // input beat layout
  localparam int IN_W          = 480;
  localparam int A_MIN_LSB     = 0;
  localparam int A_MAX_LSB     = A_MIN_LSB + VEC_W;
  localparam int A_VEL_LSB     = A_MAX_LSB + VEC_W;
  localparam int A_PROPS_LSB   = A_VEL_LSB + VEC_W;
  localparam int B_MIN_LSB     = A_PROPS_LSB + PROPS_W;
  localparam int B_MAX_LSB     = B_MIN_LSB + VEC_W;
  localparam int B_VEL_LSB     = B_MAX_LSB + VEC_W;
  localparam int B_PROPS_LSB   = B_VEL_LSB + VEC_W;
  localparam int AFF_BIT       = B_PROPS_LSB + PROPS_W;

  // props layout
  localparam int MASS_LSB   = 0;
  localparam int BOUNCE_LSB = 16;
  localparam int FRIC_LSB   = 32;
  localparam int PRIO_LSB   = 48;

  localparam int OUT_W = 200;

  localparam logic [1:0] PRIO_TOP = 2'd3;
  localparam logic [1:0] PRIO_ELASTIC = 2'd1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] CLR_NONE = 2'd0;
  localparam logic [1:0] CLR_AXIS = 2'd1;
  localparam logic [1:0] CLR_ALL  = 2'd2;

  typedef logic signed [W-1:0] coord_t;

  typedef struct packed {
    logic                      hit;
    logic [1:0]                axis;
    logic signed [PUSH_W-1:0]  a_push;
    logic signed [PUSH_W-1:0]  b_push;
    logic [VEC_W-1:0]          a_vel;
    logic [VEC_W-1:0]          b_vel;
    logic                      a_fl;
    logic                      b_fl;
    logic [15:0]               fric;
    logic [1:0]                a_cl;
    logic [1:0]                b_cl;
    logic                      elastic;
    logic                      refl_a;
    logic                      refl_b;
    logic signed [RPROD_W-1:0] rprod;
    logic [LANES-1:0]          neg;
    logic [LANES-1:0]          ovf;
  } meta_t;

endpackage
`default_nettype wire

@@ sv/acr_front.sv @@
`default_nettype none
module acr_front (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire logic [acr_pkg::IN_W-1:0]                 in_data,
  output logic                                          out_valid,
  output acr_pkg::meta_t                                meta,
  output logic [acr_pkg::LANES-1:0][acr_pkg::REM_W-1:0] rem0,
  output logic [acr_pkg::LANES-1:0][acr_pkg::Q_W-1:0]   wrd0,
  output logic [acr_pkg::DEN_W-1:0]                     den
);

  localparam int W = acr_pkg::W;
  localparam int SW = W + 1;
  localparam int CW = W + 2;

  // stage 1: registered beat
  logic [acr_pkg::IN_W-1:0] raw_r;
  logic                     v1_r, v2_r, v3_r, v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) raw_r <= in_data;
  end

  // stage 2: sums, extents, overlap, elastic products
  logic signed [SW-1:0] sa2_r [3];
  logic signed [SW-1:0] sb2_r [3];
  logic signed [SW-1:0] ea2_r [3];
  logic signed [SW-1:0] eb2_r [3];
  logic signed [acr_pkg::PROD_W-1:0] pa1_r [3];
  logic signed [acr_pkg::PROD_W-1:0] pa2_r [3];
  logic signed [acr_pkg::PROD_W-1:0] pb1_r [3];
  logic signed [acr_pkg::PROD_W-1:0] pb2_r [3];
  logic                     hit2_r;
  logic [acr_pkg::VEC_W-1:0] va2_r, vb2_r;
  logic [acr_pkg::PROPS_W-1:0] ap2_r, bp2_r;
  logic                     aff2_r;

  always_ff @(posedge clk) begin
    logic [acr_pkg::MASS_W-1:0] ma, mb;
    logic signed [acr_pkg::DEN_W-1:0] dm;
    acr_pkg::coord_t amin, amax, bmin, bmax, va, vb;
    logic hit;
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      ma = raw_r[acr_pkg::A_PROPS_LSB + acr_pkg::MASS_LSB +: acr_pkg::MASS_W];
      mb = raw_r[acr_pkg::B_PROPS_LSB + acr_pkg::MASS_LSB +: acr_pkg::MASS_W];
      dm = $signed({1'b0, ma}) - $signed({1'b0, mb});
      hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
        amin = raw_r[acr_pkg::A_MIN_LSB + i*W +: W];
        amax = raw_r[acr_pkg::A_MAX_LSB + i*W +: W];
        bmin = raw_r[acr_pkg::B_MIN_LSB + i*W +: W];
        bmax = raw_r[acr_pkg::B_MAX_LSB + i*W +: W];
        va   = raw_r[acr_pkg::A_VEL_LSB + i*W +: W];
        vb   = raw_r[acr_pkg::B_VEL_LSB + i*W +: W];
        if (!(amin <= bmax && amax >= bmin)) hit = 1'b0;
        sa2_r[i] <= SW'(amin) + SW'(amax);
        sb2_r[i] <= SW'(bmin) + SW'(bmax);
        ea2_r[i] <= SW'(amax) - SW'(amin);
        eb2_r[i] <= SW'(bmax) - SW'(bmin);
        pa1_r[i] <= va * dm;
        pa2_r[i] <= $signed({1'b0, mb}) * vb;
        pb1_r[i] <= vb * (-dm);
        pb2_r[i] <= $signed({1'b0, ma}) * va;
      end
      hit2_r <= hit;
      va2_r  <= raw_r[acr_pkg::A_VEL_LSB +: acr_pkg::VEC_W];
      vb2_r  <= raw_r[acr_pkg::B_VEL_LSB +: acr_pkg::VEC_W];
      ap2_r  <= raw_r[acr_pkg::A_PROPS_LSB +: acr_pkg::PROPS_W];
      bp2_r  <= raw_r[acr_pkg::B_PROPS_LSB +: acr_pkg::PROPS_W];
      aff2_r <= raw_r[acr_pkg::AFF_BIT];
    end
  end

  // stage 3: penetration per axis, elastic numerators
  logic signed [acr_pkg::D_W-1:0]   d3_r [3];
  logic                             gt3_r [3];
  logic signed [acr_pkg::NUM_W-1:0] na3_r [3];
  logic signed [acr_pkg::NUM_W-1:0] nb3_r [3];
  logic                             hit3_r;
  logic [acr_pkg::VEC_W-1:0]        va3_r, vb3_r;
  logic [acr_pkg::PROPS_W-1:0]      ap3_r, bp3_r;
  logic                             aff3_r;
  logic [acr_pkg::DEN_W-1:0]        den3_r;
  logic [acr_pkg::DEN_W-1:0]        sc3_r;

  always_ff @(posedge clk) begin
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] ac;
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c  = CW'(sa2_r[i]) - CW'(sb2_r[i]);
        ac = c[CW-1] ? -c : c;
        d3_r[i]  <= acr_pkg::D_W'(ea2_r[i]) + acr_pkg::D_W'(eb2_r[i]) - acr_pkg::D_W'(ac);
        gt3_r[i] <= (c > 0);
        na3_r[i] <= acr_pkg::NUM_W'(pa1_r[i]) + (acr_pkg::NUM_W'(pa2_r[i]) <<< 1);
        nb3_r[i] <= acr_pkg::NUM_W'(pb1_r[i]) + (acr_pkg::NUM_W'(pb2_r[i]) <<< 1);
      end
      hit3_r <= hit2_r;
      va3_r  <= va2_r;
      vb3_r  <= vb2_r;
      ap3_r  <= ap2_r;
      bp3_r  <= bp2_r;
      aff3_r <= aff2_r;
      den3_r <= acr_pkg::DEN_W'(ap2_r[acr_pkg::MASS_LSB +: acr_pkg::MASS_W])
              + acr_pkg::DEN_W'(bp2_r[acr_pkg::MASS_LSB +: acr_pkg::MASS_W]);
      sc3_r  <= acr_pkg::DEN_W'(ap2_r[acr_pkg::BOUNCE_LSB +: 16])
              + acr_pkg::DEN_W'(bp2_r[acr_pkg::BOUNCE_LSB +: 16]);
    end
  end

  // stage 4: axis choice, pushes, flags, divider operands
  function automatic logic signed [acr_pkg::PUSH_W-1:0] sat_push(
    input logic signed [acr_pkg::D_W-1:0] v
  );
    logic signed [acr_pkg::D_W-1:0] hi;
    logic signed [acr_pkg::D_W-1:0] lo;
    hi = acr_pkg::D_W'((1 << (acr_pkg::PUSH_W - 1)) - 1);
    lo = -hi - acr_pkg::D_W'(1);
    if (v > hi) return acr_pkg::PUSH_W'(hi);
    else if (v < lo) return acr_pkg::PUSH_W'(lo);
    else return acr_pkg::PUSH_W'(v);
  endfunction

  acr_pkg::meta_t m_nxt;
  logic [acr_pkg::LANES-1:0][acr_pkg::REM_W-1:0] rem_nxt;
  logic [acr_pkg::LANES-1:0][acr_pkg::Q_W-1:0]   wrd_nxt;

  always_comb begin
    logic [1:0] pa, pb;
    logic [1:0] ax;
    logic       go, above, into;
    logic signed [acr_pkg::D_W-1:0] dsel, full, half, ap, bp;
    acr_pkg::coord_t vsel;
    logic signed [acr_pkg::NUM_W-1:0] n;
    logic [acr_pkg::NUM_W-1:0] mag;
    pa = ap3_r[acr_pkg::PRIO_LSB +: 2];
    pb = bp3_r[acr_pkg::PRIO_LSB +: 2];
    go = hit3_r && !(pa == acr_pkg::PRIO_TOP && pb == acr_pkg::PRIO_TOP);
    if (d3_r[0] <= d3_r[1] && d3_r[0] <= d3_r[2]) ax = acr_pkg::AXIS_X;
    else if (d3_r[1] <= d3_r[2]) ax = acr_pkg::AXIS_Y;
    else ax = acr_pkg::AXIS_Z;
    dsel  = d3_r[ax];
    above = gt3_r[ax];
    full  = dsel >>> 1;
    half  = dsel >>> 2;
    ap = '0;
    bp = '0;
    into = 1'b0;
    vsel = (pa > pb) ? acr_pkg::coord_t'(vb3_r[ax*acr_pkg::W +: acr_pkg::W])
                     : acr_pkg::coord_t'(va3_r[ax*acr_pkg::W +: acr_pkg::W]);
    m_nxt = '0;
    m_nxt.hit   = hit3_r;
    m_nxt.a_vel = va3_r;
    m_nxt.b_vel = vb3_r;
    if (go) begin
      m_nxt.axis = ax;
      if (pa == pb) begin
        ap = above ? half : -half;
        bp = -ap;
        if (ax == acr_pkg::AXIS_Y) begin
          if (above) begin
            m_nxt.a_fl = 1'b1;
            m_nxt.fric = bp3_r[acr_pkg::FRIC_LSB +: 16];
          end else begin
            m_nxt.b_fl = 1'b1;
            m_nxt.fric = ap3_r[acr_pkg::FRIC_LSB +: 16];
          end
        end
        if (pa == acr_pkg::PRIO_ELASTIC && aff3_r) begin
          m_nxt.elastic = (den3_r != '0);
          m_nxt.a_cl = acr_pkg::CLR_ALL;
          m_nxt.b_cl = acr_pkg::CLR_ALL;
        end
      end else if (pa > pb) begin
        bp = above ? -full : full;
        if (!above && ax == acr_pkg::AXIS_Y) begin
          m_nxt.b_fl = 1'b1;
          m_nxt.fric = ap3_r[acr_pkg::FRIC_LSB +: 16];
        end
        into = above ? (vsel > 0) : (vsel < 0);
        if (aff3_r) begin
          if (into) m_nxt.refl_b = 1'b1;
          else if (vsel == 0) m_nxt.b_cl = acr_pkg::CLR_AXIS;
        end
      end else begin
        ap = above ? full : -full;
        if (above && ax == acr_pkg::AXIS_Y) begin
          m_nxt.a_fl = 1'b1;
          m_nxt.fric = bp3_r[acr_pkg::FRIC_LSB +: 16];
        end
        into = above ? (vsel < 0) : (vsel > 0);
        if (aff3_r) begin
          if (into) m_nxt.refl_a = 1'b1;
          else if (vsel == 0) m_nxt.a_cl = acr_pkg::CLR_AXIS;
        end
      end
    end
    m_nxt.a_push = sat_push(ap);
    m_nxt.b_push = sat_push(bp);
    m_nxt.rprod  = vsel * $signed({1'b0, sc3_r});
    // magnitude split: high part seeds the remainder, low part is shifted in
    for (int l = 0; l < acr_pkg::LANES; l++) begin
      n = (l < 3) ? na3_r[l % 3] : nb3_r[l % 3];
      m_nxt.neg[l] = n[acr_pkg::NUM_W-1];
      mag = n[acr_pkg::NUM_W-1] ? acr_pkg::NUM_W'(-n) : acr_pkg::NUM_W'(n);
      m_nxt.ovf[l] = (mag >= {2'b00, den3_r, {acr_pkg::Q_W{1'b0}}});
      rem_nxt[l] = mag[acr_pkg::Q_W +: acr_pkg::REM_W];
      wrd_nxt[l] = mag[acr_pkg::Q_W-1:0];
    end
  end

  acr_pkg::meta_t m_r;
  logic [acr_pkg::LANES-1:0][acr_pkg::REM_W-1:0] rem_r;
  logic [acr_pkg::LANES-1:0][acr_pkg::Q_W-1:0]   wrd_r;
  logic [acr_pkg::DEN_W-1:0]                     den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      m_r   <= m_nxt;
      rem_r <= rem_nxt;
      wrd_r <= wrd_nxt;
      den_r <= den3_r;
    end
  end

  assign out_valid = v4_r;
  assign meta      = m_r;
  assign rem0      = rem_r;
  assign wrd0      = wrd_r;
  assign den       = den_r;

  a_one_reflect: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> !(m_r.refl_a && m_r.refl_b))
    else $error("both bodies marked for reflection");

endmodule
`default_nettype wire

@@ sv/acr_div.sv @@
`default_nettype none
module acr_div (
  input  wire logic                                     clk,
  input  wire logic                                     en,
  input  wire logic [acr_pkg::LANES-1:0][acr_pkg::REM_W-1:0] rem_i,
  input  wire logic [acr_pkg::LANES-1:0][acr_pkg::Q_W-1:0]   wrd_i,
  input  wire logic [acr_pkg::DEN_W-1:0]                den_i,
  output logic [acr_pkg::LANES-1:0][acr_pkg::Q_W-1:0]   q_o
);

  localparam int STEPS = acr_pkg::DIV_STEPS;
  localparam int RW = acr_pkg::REM_W;
  localparam int QW = acr_pkg::Q_W;

  logic [acr_pkg::LANES-1:0][RW-1:0] rem_r [STEPS];
  logic [acr_pkg::LANES-1:0][QW-1:0] wrd_r [STEPS];
  logic [acr_pkg::DEN_W-1:0]         den_r [STEPS];

  // one restoring step per stage; the word shifts numerator bits out and quotient bits in
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [acr_pkg::LANES-1:0][RW-1:0] rem_src;
    logic [acr_pkg::LANES-1:0][QW-1:0] wrd_src;
    logic [acr_pkg::DEN_W-1:0]         den_src;
    if (k == 0) begin : g_first
      assign rem_src = rem_i;
      assign wrd_src = wrd_i;
      assign den_src = den_i;
    end else begin : g_next
      assign rem_src = rem_r[k-1];
      assign wrd_src = wrd_r[k-1];
      assign den_src = den_r[k-1];
    end
    always_ff @(posedge clk) begin
      logic [RW:0] r2;
      if (en) begin
        for (int l = 0; l < acr_pkg::LANES; l++) begin
          r2 = {rem_src[l], wrd_src[l][QW-1]};
          if (r2 >= {1'b0, den_src}) begin
            rem_r[k][l] <= RW'(r2 - {1'b0, den_src});
            wrd_r[k][l] <= {wrd_src[l][QW-2:0], 1'b1};
          end else begin
            rem_r[k][l] <= RW'(r2);
            wrd_r[k][l] <= {wrd_src[l][QW-2:0], 1'b0};
          end
        end
        den_r[k] <= den_src;
      end
    end
  end

  assign q_o = wrd_r[STEPS-1];

endmodule
`default_nettype wire

@@ sv/aabb_collision_resolve_core.sv @@
`default_nettype none
// stages from an accepted input beat to its result beat
// (4 front stages, 21 divider stages for the elastic exchange, 1 output register)
// throughput: one beat per cycle; any output stall freezes the whole pipeline
// reset: rst_n low clears all valid bits, so no result beat is pending afterwards
module aabb_collision_resolve_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // a_box_min, a_box_max, a_velocity, a_props, b_box_min, b_box_max,
  // b_velocity, b_props, affect_velocity, zero pad
  input  wire logic [acr_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // collided, push_axis, a_push, b_push, a_velocity_new, b_velocity_new,
  // a_on_floor, b_on_floor, floor_friction, a_clear_code, b_clear_code, zero pad
  output logic [acr_pkg::OUT_W-1:0]      out_tdata
);

  localparam int W = acr_pkg::W;
  localparam int STEPS = acr_pkg::DIV_STEPS;

  logic en;
  logic out_tvalid_r;
  logic [acr_pkg::OUT_W-1:0] out_tdata_r;

  assign en = !out_tvalid_r || out_tready;
  assign in_tready = en;

  logic                  f_valid;
  acr_pkg::meta_t        f_meta;
  logic [acr_pkg::LANES-1:0][acr_pkg::REM_W-1:0] f_rem;
  logic [acr_pkg::LANES-1:0][acr_pkg::Q_W-1:0]   f_wrd;
  logic [acr_pkg::DEN_W-1:0]                     f_den;
  logic [acr_pkg::LANES-1:0][acr_pkg::Q_W-1:0]   q;

  acr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .out_valid (f_valid),
    .meta      (f_meta),
    .rem0      (f_rem),
    .wrd0      (f_wrd),
    .den       (f_den)
  );

  acr_div u_div (
    .clk   (clk),
    .en    (en),
    .rem_i (f_rem),
    .wrd_i (f_wrd),
    .den_i (f_den),
    .q_o   (q)
  );

  // sideband rides alongside the divider stages
  acr_pkg::meta_t meta_d_r [STEPS];
  logic           vd_r     [STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STEPS; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= f_valid;
      for (int k = 1; k < STEPS; k++) vd_r[k] <= vd_r[k-1];
    end
    if (en) begin
      meta_d_r[0] <= f_meta;
      for (int k = 1; k < STEPS; k++) meta_d_r[k] <= meta_d_r[k-1];
    end
  end

  function automatic acr_pkg::coord_t sat_q(
    input logic [acr_pkg::Q_W-1:0] qv,
    input logic neg,
    input logic ovf
  );
    logic [W-1:0] hi;
    logic [W-1:0] lo;
    hi = {1'b0, {(W-1){1'b1}}};
    lo = {1'b1, {(W-1){1'b0}}};
    if (ovf) return neg ? lo : hi;
    else if (!neg) return (qv > hi) ? hi : qv;
    else return (qv > lo) ? lo : W'(-qv);
  endfunction

  acr_pkg::meta_t mo;
  logic [acr_pkg::OUT_W-1:0] out_nxt;

  always_comb begin
    logic signed [acr_pkg::RPROD_W-1:0] biased;
    logic signed [acr_pkg::RPROD_W-1:0] t;
    logic signed [acr_pkg::RPROD_W-1:0] r;
    acr_pkg::coord_t rfl;
    logic [acr_pkg::VEC_W-1:0] av, bv;
    mo = meta_d_r[STEPS-1];
    // divide by 8192 rounding toward zero, then negate
    biased = mo.rprod[acr_pkg::RPROD_W-1]
           ? mo.rprod + acr_pkg::RPROD_W'((1 << acr_pkg::REFL_SHIFT) - 1) : mo.rprod;
    t = biased >>> acr_pkg::REFL_SHIFT;
    r = -t;
    if (r > acr_pkg::RPROD_W'((1 << (W-1)) - 1)) rfl = {1'b0, {(W-1){1'b1}}};
    else if (r < -acr_pkg::RPROD_W'(1 << (W-1))) rfl = {1'b1, {(W-1){1'b0}}};
    else rfl = W'(r);
    av = mo.a_vel;
    bv = mo.b_vel;
    for (int i = 0; i < 3; i++) begin
      if (mo.elastic) begin
        av[i*W +: W] = sat_q(q[i], mo.neg[i], mo.ovf[i]);
        bv[i*W +: W] = sat_q(q[i+3], mo.neg[i+3], mo.ovf[i+3]);
      end else begin
        if (mo.refl_a && mo.axis == 2'(i)) av[i*W +: W] = rfl;
        if (mo.refl_b && mo.axis == 2'(i)) bv[i*W +: W] = rfl;
      end
    end
    out_nxt = {3'b000, mo.b_cl, mo.a_cl, mo.fric, mo.b_fl, mo.a_fl, bv, av,
               mo.b_push, mo.a_push, mo.axis, mo.hit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vd_r[STEPS-1];
    end
    if (en) out_tdata_r <= out_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_miss_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tdata_r[0] |-> out_tdata_r[48:1] == '0)
    else $error("pushes or axis set without a collision");

  a_floor_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[175] && out_tdata_r[176]))
    else $error("both bodies flagged on floor");

  a_fric_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tdata_r[175] && !out_tdata_r[176] |-> out_tdata_r[192:177] == '0)
    else $error("friction reported with no floor contact");

endmodule
`default_nettype wire
